/* hdl/merge_sort_engine_macros.svh */
// ----------------------------------------------------------------------------
// merge_sort_engine_macros
// Assertion macros shared by the merge sort engine.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_MACROS_SVH
`define MERGE_SORT_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mse_pkg.sv */
// ----------------------------------------------------------------------------
// mse_pkg
// Types and constants of the merge sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_word;

    typedef struct packed {
        t_word element;
        logic  final_item;
    } t_in_beat;

    typedef struct packed {
        t_word sorted_value;
        logic  last_out;
        logic  overflowed;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PASS,
        S_SEG,
        S_GET_L,
        S_GET_R,
        S_MERGE,
        S_FILL,
        S_OUT_CAP,
        S_OUT_HOLD
    } t_state;

endpackage

/* hdl/merge_sort_engine.sv */
// ----------------------------------------------------------------------------
// merge_sort_engine: beats load in S_LOAD; the sort runs ceil(log2 N) passes over the
// segments via S_SEG, S_GET_L, S_GET_R, S_MERGE and S_FILL (one comparator, one read
// port). S_PASS reads the first result, S_OUT_CAP registers it and S_OUT_HOLD keeps it
// until unstalled, then moves on. Reset clears control, count and flags; input is
// stalled in reset; the buffers are uncleared and only read where written for this set.
// ----------------------------------------------------------------------------
`include "merge_sort_engine_macros.svh"

module merge_sort_engine
    import mse_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_ELEMENTS);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic           r_drop, n_drop;
    logic           r_src, n_src;
    logic [CW:0]    r_width, n_width;
    logic [CW-1:0]  r_lo, n_lo;
    logic [CW-1:0]  r_mid, n_mid;
    logic [CW-1:0]  r_hi, n_hi;
    logic [CW-1:0]  r_l, n_l;
    logic [CW-1:0]  r_r, n_r;
    logic [CW-1:0]  r_k, n_k;
    t_word          r_lval, n_lval;
    t_word          r_rval, n_rval;
    logic           r_fill_left, n_fill_left;
    logic [CW-1:0]  r_out_idx, n_out_idx;
    logic           r_out_valid, n_out_valid;
    t_out_beat      r_out_beat, n_out_beat;
    logic           r_desc;

    logic [AW-1:0]  rd_addr, wr_addr;
    t_word          wr_data, rd_data_a, rd_data_b, rd_data;
    logic           we_a, we_b;
    logic           left_first;

    logic [CW+1:0]  mid_sum, hi_sum, n_ext;
    logic [CW-1:0]  seg_mid, seg_hi;
    logic [CW-1:0]  k_inc, l_inc, r_inc, out_inc;
    logic           l_has, r_has, take_l;

    mse_mem #(.DEPTH(MAX_ELEMENTS)) u_mem_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data_a)
    );

    mse_mem #(.DEPTH(MAX_ELEMENTS)) u_mem_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data_b)
    );

    mse_cmp u_cmp (
        .i_left       (r_lval),
        .i_right      (r_rval),
        .i_descending (r_desc),
        .o_left_first (left_first)
    );

    assign rd_data = r_src ? rd_data_b : rd_data_a;

    assign mid_sum = {2'b00, r_lo} + {1'b0, r_width};
    assign hi_sum  = {2'b00, r_lo} + {r_width, 1'b0};
    assign n_ext   = {2'b00, r_count};
    assign seg_mid = (mid_sum > n_ext) ? r_count : mid_sum[CW-1:0];
    assign seg_hi  = (hi_sum > n_ext) ? r_count : hi_sum[CW-1:0];

    assign k_inc   = r_k + 1'b1;
    assign l_inc   = r_l + 1'b1;
    assign r_inc   = r_r + 1'b1;
    assign out_inc = r_out_idx + 1'b1;
    assign l_has   = (r_l < r_mid);
    assign r_has   = (r_r < r_hi);
    assign take_l  = l_has && (!r_has || left_first);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_src       <= 1'b0;
            r_width     <= '0;
            r_out_valid <= 1'b0;
            r_desc      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_src       <= n_src;
            r_width     <= n_width;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_desc <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_mid       <= n_mid;
        r_hi        <= n_hi;
        r_l         <= n_l;
        r_r         <= n_r;
        r_k         <= n_k;
        r_lval      <= n_lval;
        r_rval      <= n_rval;
        r_fill_left <= n_fill_left;
        r_out_idx   <= n_out_idx;
        r_out_beat  <= n_out_beat;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_src       = r_src;
        n_width     = r_width;
        n_lo        = r_lo;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_l         = r_l;
        n_r         = r_r;
        n_k         = r_k;
        n_lval      = r_lval;
        n_rval      = r_rval;
        n_fill_left = r_fill_left;
        n_out_idx   = r_out_idx;
        n_out_valid = r_out_valid;
        n_out_beat  = r_out_beat;
        rd_addr     = '0;
        wr_addr     = r_k[AW-1:0];
        wr_data     = take_l ? r_lval : r_rval;
        we_a        = 1'b0;
        we_b        = 1'b0;

        case (r_state)
            S_LOAD: begin
                wr_addr = r_count[AW-1:0];
                wr_data = i_in_beat.element;
                if (i_in_valid) begin
                    if (r_count != FULL) begin
                        we_a    = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_in_beat.final_item) begin
                        n_width = (CW+1)'(1);
                        n_src   = 1'b0;
                        n_state = S_PASS;
                    end
                end
            end
            S_PASS: begin
                if (r_width < {1'b0, r_count}) begin
                    n_lo    = '0;
                    n_state = S_SEG;
                end else begin
                    rd_addr   = '0;
                    n_out_idx = '0;
                    n_state   = S_OUT_CAP;
                end
            end
            S_SEG: begin
                n_mid   = seg_mid;
                n_hi    = seg_hi;
                n_l     = r_lo;
                n_r     = seg_mid;
                n_k     = r_lo;
                rd_addr = r_lo[AW-1:0];
                n_state = S_GET_L;
            end
            S_GET_L: begin
                n_lval = rd_data;
                if (r_has) begin
                    rd_addr = r_r[AW-1:0];
                    n_state = S_GET_R;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_GET_R: begin
                n_rval  = rd_data;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                we_a = r_src;
                we_b = !r_src;
                n_k  = k_inc;
                if (take_l) begin
                    n_l = l_inc;
                end else begin
                    n_r = r_inc;
                end
                if (k_inc == r_hi) begin
                    if (r_hi == r_count) begin
                        n_width = {r_width[CW-1:0], 1'b0};
                        n_src   = !r_src;
                        n_state = S_PASS;
                    end else begin
                        n_lo    = r_hi;
                        n_state = S_SEG;
                    end
                end else if (take_l && (l_inc < r_mid)) begin
                    rd_addr     = l_inc[AW-1:0];
                    n_fill_left = 1'b1;
                    n_state     = S_FILL;
                end else if (!take_l && (r_inc < r_hi)) begin
                    rd_addr     = r_inc[AW-1:0];
                    n_fill_left = 1'b0;
                    n_state     = S_FILL;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_FILL: begin
                if (r_fill_left) begin
                    n_lval = rd_data;
                end else begin
                    n_rval = rd_data;
                end
                n_state = S_MERGE;
            end
            S_OUT_CAP: begin
                n_out_beat.sorted_value = rd_data;
                n_out_beat.last_out     = (out_inc == r_count);
                n_out_beat.overflowed   = r_drop;
                n_out_valid             = 1'b1;
                n_state                 = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out_beat.last_out) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_out_idx = out_inc;
                        rd_addr   = out_inc[AW-1:0];
                        n_state   = S_OUT_CAP;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_LOAD) || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    `MSE_ASSERT_NOW(a_out_blocks_in, i_clk, i_rst_n, o_out_valid, o_in_stall, "input open during output")
    `MSE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL, "count beyond depth")
    `MSE_ASSERT_NOW(a_merge_in_seg, i_clk, i_rst_n, r_state == S_MERGE, (r_k < r_hi) && (l_has || r_has), "merge past segment")
    `MSE_ASSERT_NEXT(a_set_cleared, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_out_beat.last_out, (r_count == '0) && !r_drop && (r_state == S_LOAD), "set not cleared after last beat")

endmodule

/* hdl/mse_mem.sv */
// ----------------------------------------------------------------------------
// mse_mem
// Element buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mse_mem
    import mse_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_word                    i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_word                    o_rdata
);

    t_word r_mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/mse_cmp.sv */
// ----------------------------------------------------------------------------
// mse_cmp
// Shared comparator: decides whether the left head goes out first.
// ----------------------------------------------------------------------------
module mse_cmp
    import mse_pkg::*;
(
    input  t_word i_left,
    input  t_word i_right,
    input  logic  i_descending,
    output logic  o_left_first
);

    // ties favour the left run to keep the sort stable
    always_comb begin
        if (i_descending) begin
            o_left_first = (i_left >= i_right);
        end else begin
            o_left_first = (i_left <= i_right);
        end
    end

endmodule

/* tb/sv/merge_sort_engine_tb.sv */
// ----------------------------------------------------------------------------
// merge_sort_engine_tb
// Self-checking bench for the merge sort engine. Sets of signed words are
// streamed in, and every sorted beat is compared field by field against a
// stable insertion sort kept in the bench. A directed table covers the
// extremes, ties and one-word sets in both orders. Random sets follow,
// including a full buffer and an overflowing set, with random gaps on both
// sides and long output hold-offs that back the engine up into its input.
// ----------------------------------------------------------------------------
module merge_sort_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mse_pkg::*;

    localparam int DEPTH       = 64;
    localparam int SETTLE      = 8;
    localparam int PHASE_BEATS = 64;
    localparam int HOLD_CYCLES = 250;

    typedef struct packed {
        t_word element;
        logic  final_item;
        logic  has_exp;
        t_word exp_value;
        logic  exp_last;
        logic  exp_ovf;
    } t_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;

    // bench copy of the engine state
    t_word     set_store [DEPTH];
    int        set_fill    = 0;
    logic      set_dropped = 1'b0;
    logic      order_desc  = 1'b0;
    t_out_beat sorted_batch [$];
    t_out_beat expected_results [$];

    int fault_count  = 0;
    int results_seen = 0;
    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;

    t_word extreme_values [4] = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh00000000, 32'shFFFFFFFF};

    // one-word sets carry their answer; longer sets go through the sorter
    t_row directed_rows [13] = '{
        '{32'sh7FFFFFFF, 1'b1, 1'b1, 32'sh7FFFFFFF, 1'b1, 1'b0},
        '{32'sh80000000, 1'b1, 1'b1, 32'sh80000000, 1'b1, 1'b0},
        '{32'sh00000000, 1'b1, 1'b1, 32'sh00000000, 1'b1, 1'b0},
        '{32'shFFFFFFFF, 1'b1, 1'b1, 32'shFFFFFFFF, 1'b1, 1'b0},
        '{32'sh00000005, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
        '{32'shFFFFFFFD, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
        '{32'sh00000005, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
        '{32'sh80000000, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
        '{32'sh7FFFFFFF, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
        '{32'shFFFFFFFF, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
        '{32'sh00000000, 1'b1, 1'b0, 32'sh0, 1'b0, 1'b0},
        '{32'sh00000002, 1'b0, 1'b0, 32'sh0, 1'b0, 1'b0},
        '{32'sh00000001, 1'b1, 1'b0, 32'sh0, 1'b0, 1'b0}
    };

    merge_sort_engine #(
        .MAX_ELEMENTS(DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void log_fault(string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // load one beat; on the closing beat sort the set (stable) into sorted_batch
    function automatic void absorb_beat(t_word value, logic fin);
        t_word key;
        int    i;
        int    j;
        sorted_batch.delete();
        if (set_fill < DEPTH) begin
            set_store[set_fill] = value;
            set_fill++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!fin) begin
            return;
        end
        for (i = 1; i < set_fill; i++) begin
            key = set_store[i];
            j   = i - 1;
            while (j >= 0 && (order_desc ? key > set_store[j] : key < set_store[j])) begin
                set_store[j + 1] = set_store[j];
                j--;
            end
            set_store[j + 1] = key;
        end
        for (i = 0; i < set_fill; i++) begin
            sorted_batch.push_back('{sorted_value: set_store[i],
                                     last_out:     (i == set_fill - 1),
                                     overflowed:   set_dropped});
        end
        set_fill    = 0;
        set_dropped = 1'b0;
    endfunction

    function automatic void check_result(t_out_beat got);
        t_out_beat want;
        if (expected_results.size() == 0) begin
            log_fault($sformatf("unexpected beat: value=%0d last=%0b ovf=%0b",
                                got.sorted_value, got.last_out, got.overflowed));
            return;
        end
        want = expected_results.pop_front();
        if (got.sorted_value !== want.sorted_value || got.last_out !== want.last_out ||
            got.overflowed !== want.overflowed) begin
            log_fault($sformatf("beat %0d: expected value=%0d last=%0b ovf=%0b, got value=%0d last=%0b ovf=%0b",
                                results_seen, want.sorted_value, want.last_out, want.overflowed,
                                got.sorted_value, got.last_out, got.overflowed));
        end
    endfunction

    task automatic offer_beat(input t_word value, input logic fin, input bit use_sorter);
        int   gap;
        logic stalled;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{element: value, final_item: fin};
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        absorb_beat(value, fin);
        if (use_sorter) begin
            foreach (sorted_batch[k]) begin
                expected_results.push_back(sorted_batch[k]);
            end
        end
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_order(input logic desc);
        cfg_we    <= 1'b1;
        cfg_wdata <= desc;
        @(posedge clk);
        cfg_we     <= 1'b0;
        order_desc = desc;
    endtask

    initial begin : result_side
        int        wait_cycles;
        logic      seen_valid;
        t_out_beat got;
        while (!rst_n) begin
            @(posedge clk);
        end
        forever begin
            wait_cycles = rx_idle ? $urandom_range(0, 8) : 0;
            // long hold-off so the engine fills and stalls its input
            if (results_seen == 60 || results_seen == 180) begin
                wait_cycles = HOLD_CYCLES;
            end
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do begin
                @(negedge clk);
                seen_valid = out_valid;
                got        = out_beat;
                @(posedge clk);
            end while (!seen_valid);
            check_result(got);
            results_seen++;
            if (results_seen % 16 == 0) begin
                rx_idle = ($urandom_range(0, 2) != 0);
            end
        end
    end

    initial begin : stimulus
        int    round;
        int    phase;
        int    phase_beats;
        int    set_len;
        int    k;
        t_word value;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (round = 0; round < 2; round++) begin
            if (round == 1) begin
                set_order(1'b1);
            end
            foreach (directed_rows[r]) begin
                offer_beat(directed_rows[r].element, directed_rows[r].final_item,
                           !directed_rows[r].has_exp);
                if (directed_rows[r].has_exp) begin
                    expected_results.push_back('{sorted_value: directed_rows[r].exp_value,
                                                 last_out:     directed_rows[r].exp_last,
                                                 overflowed:   directed_rows[r].exp_ovf});
                end
            end
            drain_and_settle();
        end

        for (phase = 0; phase < 4; phase++) begin
            set_order(phase % 2 == 1);
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS) begin
                if (phase_beats == 0 && phase == 1) begin
                    set_len = DEPTH + 2;
                end else if (phase_beats == 0 && phase == 2) begin
                    set_len = DEPTH;
                end else begin
                    case ($urandom_range(0, 19))
                        0:       set_len = $urandom_range(DEPTH, DEPTH + 4);
                        1, 2:    set_len = $urandom_range(17, DEPTH - 1);
                        default: set_len = $urandom_range(1, 16);
                    endcase
                end
                tx_idle = ($urandom_range(0, 3) != 0);
                for (k = 0; k < set_len; k++) begin
                    case ($urandom_range(0, 9))
                        0:       value = extreme_values[$urandom_range(0, 3)];
                        1, 2, 3: value = t_word'(int'($urandom_range(0, 6)) - 3);
                        default: value = t_word'($urandom);
                    endcase
                    offer_beat(value, k == set_len - 1, 1'b1);
                end
                phase_beats += set_len;
            end
            drain_and_settle();
        end

        fault_count += expected_results.size();
        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
